// ===== sv/max_tracking_stack_assert.svh =====
// Assertion macros shared by the max-tracking stack RTL.
`ifndef MAX_TRACKING_STACK_ASSERT_SVH
`define MAX_TRACKING_STACK_ASSERT_SVH

`ifndef SYNTHESIS
// Property checked on clk_i, off while rst_ni is low.
`define MTS_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("max_tracking_stack: assertion failed");
// Condition that must never be true.
`define MTS_ASSERT_NEVER(label, cond) \
  `MTS_ASSERT(label, !(cond))
`else
`define MTS_ASSERT(label, prop)
`define MTS_ASSERT_NEVER(label, cond)
`endif

`endif

// ===== sv/mts_pkg.sv =====
// Shared codes and types for the max-tracking stack.
`default_nettype none
package mts_pkg;

  localparam logic [1:0] CMD_PUSH = 2'd0;
  localparam logic [1:0] CMD_POP  = 2'd1;
  localparam logic [1:0] CMD_PEEK = 2'd2;

  localparam logic [1:0] STAT_DONE  = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;

  localparam logic [7:0] CAPACITY_RESET = 8'd100;

  // register index 0 of the config space
  localparam logic REG_CAPACITY = 1'b0;

  typedef enum logic [1:0] {
    S_IDLE  = 2'b01,
    S_POPRD = 2'b10
  } state_e;

endpackage
`default_nettype wire

// ===== sv/mts_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module mts_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 128,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== sv/max_tracking_stack.sv =====
// Max-tracking LIFO stack: top level with config register, control and output stage.
`default_nettype none
`include "max_tracking_stack_assert.svh"
// Bounded LIFO stack of signed words that reports the running maximum with
// every command. Each entry is stored in one RAM together with the maximum
// of itself and everything below it; the top entry and its maximum are also
// kept in registers, so push and peek need no RAM read and their result
// beat is ready at the next edge. A pop that leaves entries behind reads the
// new top from the RAM, whose read data is registered, via state S_POPRD.
// One command is worked on at a time; a new command is taken while the
// previous result is being handed off. The capacity register (address 0,
// reset 100) limits the fill to min(capacity, DEPTH); lowering it below the
// current fill keeps the entries and rejects pushes until pops make room.
// Top and maximum read as zero when the stack is empty. Command code 3 is a
// peek. No clearing pass is needed after reset: only entries below the fill
// count are ever read.
module max_tracking_stack #(
  parameter int DEPTH      = 128,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // config port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  // command channel
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  command_i,
  input  wire logic [31:0] value_i,
  // result channel
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic      [1:0]  status_o,
  output logic      [7:0]  count_o,
  output logic      [31:0] top_value_o,
  output logic      [31:0] max_value_o,
  output logic             is_empty_o
);

  localparam int DW = DATA_WIDTH;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FW = $clog2(DEPTH + 1);
  localparam int CW = (FW > 8) ? FW : 8;

  // ---------------- config register ----------------
  logic [7:0] capacity_q;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == mts_pkg::REG_CAPACITY);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= mts_pkg::CAPACITY_RESET;
    end else if (cfg_wr) begin
      capacity_q <= pwdata[7:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == mts_pkg::REG_CAPACITY) begin
      prdata = {24'd0, capacity_q};
    end
  end

  // ---------------- word conversion ----------------
  logic [DW-1:0] push_val;
  logic [DW-1:0] out_top_q;
  logic [DW-1:0] out_max_q;

  generate
    if (DW <= 32) begin : g_in_narrow
      assign push_val = value_i[DW-1:0];
    end else begin : g_in_wide
      assign push_val = {{(DW-32){value_i[31]}}, value_i};
    end
    if (DW >= 32) begin : g_out_narrow
      assign top_value_o = out_top_q[31:0];
      assign max_value_o = out_max_q[31:0];
    end else begin : g_out_wide
      assign top_value_o = {{(32-DW){out_top_q[DW-1]}}, out_top_q};
      assign max_value_o = {{(32-DW){out_max_q[DW-1]}}, out_max_q};
    end
  endgenerate

  // ---------------- stack state ----------------
  mts_pkg::state_e state_q, state_d;
  logic [FW-1:0]   fill_q, fill_d;
  logic [DW-1:0]   top_val_q, top_val_d;
  logic [DW-1:0]   top_max_q, top_max_d;

  logic            out_vld_q, out_vld_d;
  logic [1:0]      out_stat_q, out_stat_d;
  logic [7:0]      out_cnt_q, out_cnt_d;
  logic [DW-1:0]   out_top_d, out_max_d;
  logic            out_empty_q, out_empty_d;
  logic            load_out;

  logic            ram_we, ram_re;
  logic [AW-1:0]   ram_waddr, ram_raddr;
  logic [2*DW-1:0] ram_wdata, ram_rdata;

  logic            in_fire;
  logic [CW-1:0]   fill_ext, fill_d_ext, cap_ext, depth_ext, limit;
  logic            full;
  logic [FW-1:0]   fill_m2;
  logic [DW-1:0]   new_max;
  logic [DW-1:0]   cur_top, cur_max;

  assign in_ready_o = (state_q == mts_pkg::S_IDLE) && (!out_vld_q || out_ready_i);
  assign in_fire    = in_valid_i && in_ready_o;

  assign fill_ext   = CW'(fill_q);
  assign fill_d_ext = CW'(fill_d);
  assign cap_ext    = CW'(capacity_q);
  assign depth_ext  = CW'(DEPTH);
  assign limit      = (cap_ext < depth_ext) ? cap_ext : depth_ext;
  assign full       = (fill_ext >= limit);
  assign fill_m2    = fill_q - FW'(2);

  // running max goes with each entry
  assign new_max = ((fill_q == '0) || ($signed(push_val) > $signed(top_max_q)))
                   ? push_val : top_max_q;
  assign cur_top = (fill_q != '0) ? top_val_q : '0;
  assign cur_max = (fill_q != '0) ? top_max_q : '0;

  assign ram_waddr = fill_q[AW-1:0];
  assign ram_wdata = {new_max, push_val};
  assign ram_raddr = fill_m2[AW-1:0];

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    top_val_d   = top_val_q;
    top_max_d   = top_max_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    load_out    = 1'b0;
    out_stat_d  = mts_pkg::STAT_DONE;
    out_top_d   = cur_top;
    out_max_d   = cur_max;

    unique case (state_q)
      mts_pkg::S_POPRD: begin
        // new top arrives from the RAM
        top_val_d = ram_rdata[DW-1:0];
        top_max_d = ram_rdata[2*DW-1:DW];
        out_top_d = ram_rdata[DW-1:0];
        out_max_d = ram_rdata[2*DW-1:DW];
        load_out  = 1'b1;
        state_d   = mts_pkg::S_IDLE;
      end
      mts_pkg::S_IDLE: begin
        if (in_fire) begin
          unique case (command_i)
            mts_pkg::CMD_PUSH: begin
              load_out = 1'b1;
              if (full) begin
                out_stat_d = mts_pkg::STAT_FULL;
              end else begin
                ram_we    = 1'b1;
                fill_d    = fill_q + FW'(1);
                top_val_d = push_val;
                top_max_d = new_max;
                out_top_d = push_val;
                out_max_d = new_max;
              end
            end
            mts_pkg::CMD_POP: begin
              if (fill_q == '0) begin
                load_out   = 1'b1;
                out_stat_d = mts_pkg::STAT_EMPTY;
              end else if (fill_q == FW'(1)) begin
                load_out  = 1'b1;
                fill_d    = '0;
                out_top_d = '0;
                out_max_d = '0;
              end else begin
                fill_d  = fill_q - FW'(1);
                ram_re  = 1'b1;
                state_d = mts_pkg::S_POPRD;
              end
            end
            default: begin
              load_out = 1'b1;
            end
          endcase
        end
      end
      default: begin
        state_d = mts_pkg::S_IDLE;
      end
    endcase
  end

  assign out_cnt_d   = fill_d_ext[7:0];
  assign out_empty_d = (fill_d == '0);
  assign out_vld_d   = load_out ? 1'b1 : (out_ready_i ? 1'b0 : out_vld_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= mts_pkg::S_IDLE;
      fill_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      fill_q    <= fill_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_val_q <= top_val_d;
    top_max_q <= top_max_d;
    if (load_out) begin
      out_stat_q  <= out_stat_d;
      out_cnt_q   <= out_cnt_d;
      out_top_q   <= out_top_d;
      out_max_q   <= out_max_d;
      out_empty_q <= out_empty_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign status_o    = out_stat_q;
  assign count_o     = out_cnt_q;
  assign is_empty_o  = out_empty_q;

  mts_ram #(
    .WIDTH (2 * DW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // ---------------- checks ----------------
  `MTS_ASSERT_NEVER(a_fill_in_range, CW'(fill_q) > depth_ext)
  `MTS_ASSERT(a_poprd_one_cycle, (state_q == mts_pkg::S_POPRD) |=> (state_q == mts_pkg::S_IDLE))
  `MTS_ASSERT_NEVER(a_poprd_out_free, (state_q == mts_pkg::S_POPRD) && out_vld_q)
  `MTS_ASSERT(a_max_ge_top, out_vld_q |-> ($signed(out_max_q) >= $signed(out_top_q)))
  `MTS_ASSERT(a_empty_zero, (out_vld_q && out_empty_q) |-> (out_top_q == '0 && out_max_q == '0))

endmodule
`default_nettype wire
